[src/boig_pkg.sv]
// ----------------------------------------------------------------------------
// boig_pkg
// Shared widths, types and constants of the box overlap score block.
// ----------------------------------------------------------------------------
package boig_pkg;
    localparam int COORD_BITS      = 16;
    localparam int SCORE_FRAC_BITS = 16;
    localparam int SCORE_WIDTH     = 18;
    localparam int IN_BITS         = 16;
    localparam int EDGE_BITS       = COORD_BITS + 1;
    localparam int AREA_BITS       = 2 * EDGE_BITS;
    localparam int Q_BITS          = SCORE_FRAC_BITS + 1;

    localparam logic METRIC_IOU  = 1'b0;
    localparam logic METRIC_GIOU = 1'b1;

    // one stage of the restoring fraction divider
    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic                 giou;
        logic [AREA_BITS-1:0] den_i;
        logic [AREA_BITS:0]   rem_i;
        logic [Q_BITS-1:0]    quo_i;
        logic [AREA_BITS-1:0] den_g;
        logic [AREA_BITS:0]   rem_g;
        logic [Q_BITS-1:0]    quo_g;
    } t_div_stage;
endpackage

[src/box_overlap_iou_giou.sv]
// ----------------------------------------------------------------------------
// box_overlap_iou_giou
// Pipelined IoU / GIoU score of two axis-aligned boxes.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// input   | in        | i_valid / o_stall   | box_a_*, box_b_*
// output  | out       | o_valid / i_stall   | overlap_score, degenerate_pair
// config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (metric_mode)
//
// One word per cycle unless the output stalls; one divider bit per stage, in the
// order edges, products, sums, divide steps, subtract.
// Synchronous active-low reset empties the pipe and sets metric_mode to IoU.
// Output stall freezes the whole pipe, bubbles included.
// ----------------------------------------------------------------------------
module box_overlap_iou_giou
    import boig_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [IN_BITS-1:0]     i_box_a_left,
    input  logic [IN_BITS-1:0]     i_box_a_top,
    input  logic [IN_BITS-1:0]     i_box_a_width,
    input  logic [IN_BITS-1:0]     i_box_a_height,
    input  logic [IN_BITS-1:0]     i_box_b_left,
    input  logic [IN_BITS-1:0]     i_box_b_top,
    input  logic [IN_BITS-1:0]     i_box_b_width,
    input  logic [IN_BITS-1:0]     i_box_b_height,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [SCORE_WIDTH-1:0] o_overlap_score,
    output logic                   o_degenerate_pair,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);
    logic r_mode;
    logic w_adv;

    // stage 1: edges
    logic                 r1_vld, r1_giou, r1_ovl, r1_ea, r1_eb;
    logic [EDGE_BITS-1:0] r1_aw, r1_ah, r1_bw, r1_bh, r1_iw, r1_ih, r1_cw, r1_ch;
    // stage 2: areas
    logic                 r2_vld, r2_giou, r2_ea, r2_eb;
    logic [AREA_BITS-1:0] r2_aa, r2_ab, r2_in, r2_c;
    // stage 3: union, divisor setup
    t_div_stage           r3;

    assign w_adv       = !(o_valid && i_stall);
    assign o_stall     = !w_adv;
    assign o_cfg_ready = 1'b1;

    // hold metric mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= METRIC_IOU;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    logic [COORD_BITS-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic [EDGE_BITS-1:0]  ax2, ay2, bx2, by2, ix1, ix2, iy1, iy2, cx1, cx2, cy1, cy2;
    always_comb begin
        ax  = i_box_a_left[COORD_BITS-1:0];
        ay  = i_box_a_top[COORD_BITS-1:0];
        aw  = i_box_a_width[COORD_BITS-1:0];
        ah  = i_box_a_height[COORD_BITS-1:0];
        bx  = i_box_b_left[COORD_BITS-1:0];
        by  = i_box_b_top[COORD_BITS-1:0];
        bw  = i_box_b_width[COORD_BITS-1:0];
        bh  = i_box_b_height[COORD_BITS-1:0];
        ax2 = {1'b0, ax} + {1'b0, aw};
        ay2 = {1'b0, ay} + {1'b0, ah};
        bx2 = {1'b0, bx} + {1'b0, bw};
        by2 = {1'b0, by} + {1'b0, bh};
        ix1 = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
        iy1 = (ay > by) ? {1'b0, ay} : {1'b0, by};
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        cx1 = (ax < bx) ? {1'b0, ax} : {1'b0, bx};
        cy1 = (ay < by) ? {1'b0, ay} : {1'b0, by};
        cx2 = (ax2 > bx2) ? ax2 : bx2;
        cy2 = (ay2 > by2) ? ay2 : by2;
    end

    // stage 1: edge lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_valid;
        end
        if (w_adv) begin
            r1_giou <= r_mode;
            r1_ovl  <= (ix2 > ix1) && (iy2 > iy1);
            r1_ea   <= (aw == '0) || (ah == '0);
            r1_eb   <= (bw == '0) || (bh == '0);
            r1_aw   <= {1'b0, aw};
            r1_ah   <= {1'b0, ah};
            r1_bw   <= {1'b0, bw};
            r1_bh   <= {1'b0, bh};
            r1_iw   <= ix2 - ix1;
            r1_ih   <= iy2 - iy1;
            r1_cw   <= cx2 - cx1;
            r1_ch   <= cy2 - cy1;
        end
    end

    // stage 2: areas
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
        if (w_adv) begin
            r2_giou <= r1_giou;
            r2_ea   <= r1_ea;
            r2_eb   <= r1_eb;
            r2_aa   <= AREA_BITS'(r1_aw) * AREA_BITS'(r1_ah);
            r2_ab   <= AREA_BITS'(r1_bw) * AREA_BITS'(r1_bh);
            r2_in   <= r1_ovl ? AREA_BITS'(r1_iw) * AREA_BITS'(r1_ih) : '0;
            r2_c    <= AREA_BITS'(r1_cw) * AREA_BITS'(r1_ch);
        end
    end

    logic [AREA_BITS:0]   w_un;
    logic [AREA_BITS-1:0] w_c, w_gap;
    always_comb begin
        w_un  = {1'b0, r2_aa} + {1'b0, r2_ab} - {1'b0, r2_in};
        w_c   = r2_ea ? r2_ab : (r2_eb ? r2_aa : r2_c);
        w_gap = ({1'b0, w_c} >= w_un) ? w_c - w_un[AREA_BITS-1:0] : '0;
    end

    // stage 3: union and divider setup, integer quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3.vld <= 1'b0;
        end else if (w_adv) begin
            r3.vld <= r2_vld;
        end
        if (w_adv) begin
            r3.degen <= r2_ea && r2_eb;
            r3.giou  <= r2_giou;
            r3.den_i <= w_un[AREA_BITS-1:0];
            r3.den_g <= w_c;
            // numerator never exceeds the divisor
            if ({1'b0, r2_in} >= w_un && w_un != '0) begin
                r3.rem_i <= {1'b0, r2_in} - w_un;
                r3.quo_i <= Q_BITS'(1);
            end else begin
                r3.rem_i <= {1'b0, r2_in};
                r3.quo_i <= '0;
            end
            if (w_gap >= w_c && w_c != '0) begin
                r3.rem_g <= '0;
                r3.quo_g <= Q_BITS'(1);
            end else begin
                r3.rem_g <= {1'b0, w_gap};
                r3.quo_g <= '0;
            end
        end
    end

    // divide steps, one fraction bit each
    t_div_stage w_st [SCORE_FRAC_BITS+1];
    assign w_st[0] = r3;
    for (genvar g = 0; g < SCORE_FRAC_BITS; g++) begin : g_div
        boig_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_stage (w_st[g]),
            .o_stage (w_st[g+1])
        );
    end

    t_div_stage w_last;
    logic signed [Q_BITS+1:0] w_score;
    logic signed [SCORE_WIDTH-1:0] w_sat;
    localparam logic signed [Q_BITS+1:0] LimHi = (Q_BITS+2)'((1 <<< (SCORE_WIDTH-1)) - 1);
    localparam logic signed [Q_BITS+1:0] LimLo = -(Q_BITS+2)'(1 <<< (SCORE_WIDTH-1));
    always_comb begin
        w_last = w_st[SCORE_FRAC_BITS];
        // a zero divisor makes its term zero
        w_score = (w_last.den_i == '0) ? '0 : $signed({2'b00, w_last.quo_i});
        if (w_last.giou && w_last.den_g != '0) begin
            w_score = w_score - $signed({2'b00, w_last.quo_g});
        end
        if (w_score > LimHi) begin
            w_sat = SCORE_WIDTH'(LimHi);
        end else if (w_score < LimLo) begin
            w_sat = SCORE_WIDTH'(LimLo);
        end else begin
            w_sat = SCORE_WIDTH'(w_score);
        end
        if (w_last.degen) begin
            w_sat = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= w_last.vld;
        end
        if (w_adv) begin
            o_overlap_score   <= w_sat;
            o_degenerate_pair <= w_last.degen;
        end
    end
endmodule

[src/boig_div_step.sv]
// ----------------------------------------------------------------------------
// boig_div_step
// One registered step of the two parallel restoring dividers.
// ----------------------------------------------------------------------------
module boig_div_step
    import boig_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);
    t_div_stage r_stage;
    t_div_stage n_stage;
    logic [AREA_BITS:0] w_ri;
    logic [AREA_BITS:0] w_rg;

    // shift remainder, subtract divisor when it fits
    always_comb begin
        n_stage = i_stage;
        w_ri = {i_stage.rem_i[AREA_BITS-1:0], 1'b0};
        w_rg = {i_stage.rem_g[AREA_BITS-1:0], 1'b0};
        n_stage.quo_i = {i_stage.quo_i[Q_BITS-2:0], 1'b0};
        n_stage.quo_g = {i_stage.quo_g[Q_BITS-2:0], 1'b0};
        n_stage.rem_i = w_ri;
        n_stage.rem_g = w_rg;
        if (w_ri >= {1'b0, i_stage.den_i}) begin
            n_stage.rem_i    = w_ri - {1'b0, i_stage.den_i};
            n_stage.quo_i[0] = 1'b1;
        end
        if (w_rg >= {1'b0, i_stage.den_g}) begin
            n_stage.rem_g    = w_rg - {1'b0, i_stage.den_g};
            n_stage.quo_g[0] = 1'b1;
        end
    end

    // advance when the pipe moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_adv) begin
            r_stage.vld <= n_stage.vld;
        end
        if (i_adv) begin
            r_stage.degen <= n_stage.degen;
            r_stage.giou  <= n_stage.giou;
            r_stage.den_i <= n_stage.den_i;
            r_stage.rem_i <= n_stage.rem_i;
            r_stage.quo_i <= n_stage.quo_i;
            r_stage.den_g <= n_stage.den_g;
            r_stage.rem_g <= n_stage.rem_g;
            r_stage.quo_g <= n_stage.quo_g;
        end
    end

    assign o_stage = r_stage;
endmodule

[src/boig_checker.sv]
// ----------------------------------------------------------------------------
// boig_checker
// Port-level checks of the box overlap score block.
// ----------------------------------------------------------------------------
module boig_checker
    import boig_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic signed [SCORE_WIDTH-1:0] o_overlap_score,
    input logic                   o_degenerate_pair
);
    // stall only follows a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without held word");

    // held result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_overlap_score)))
        else $error("held word changed");

    // degenerate pair scores zero
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate_pair) |-> (o_overlap_score == '0))
        else $error("degenerate score nonzero");

    // score stays in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_overlap_score <= (1 <<< SCORE_FRAC_BITS)
                     && o_overlap_score >= -(1 <<< SCORE_FRAC_BITS)))
        else $error("score out of range");
endmodule

bind box_overlap_iou_giou boig_checker u_boig_checker (.*);
